[rtl/erm_pkg.sv]
// shared constants, codes and types of the event rule matrix matcher
package erm_pkg;

	localparam int ROWS_DEF  = 16;
	localparam int ROW_BYTES = 8;
	localparam int ROW_W     = ROW_BYTES * 8;
	localparam int BYTE_W    = 3;
	localparam int MAX_OUT   = 16;
	localparam int CNT_W     = $clog2(MAX_OUT + 1);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;

	localparam logic [1:0] KIND_ACCESS = 2'd0;
	localparam logic [1:0] KIND_FIRE   = 2'd1;
	localparam logic [1:0] KIND_NOFIRE = 2'd2;

	localparam logic CFG_ZONE    = 1'b0;
	localparam logic CFG_SUBZONE = 1'b1;

	// byte positions within a row
	localparam int B_OADDR  = 0;
	localparam int B_FLAGS  = 1;
	localparam int B_CMASK  = 2;
	localparam int B_CFILT  = 3;
	localparam int B_TMASK  = 4;
	localparam int B_TFILT  = 5;
	localparam int B_ACTION = 6;
	localparam int B_PARAM  = 7;

	// flag bit positions
	localparam int FL_ENABLE  = 7;
	localparam int FL_OADDR   = 6;
	localparam int FL_HARD    = 5;
	localparam int FL_ZONE    = 4;
	localparam int FL_SUBZONE = 3;
	localparam int FL_CMASK8  = 1;
	localparam int FL_CFILT8  = 0;

	localparam logic [8:0] CLASS_BIT8 = 9'h100;
	localparam logic [7:0] BYTE_ONES  = 8'hFF;

	typedef struct packed {
		logic [7:0] orig_addr;
		logic       hard_coded;
		logic [8:0] event_class;
		logic [7:0] event_type;
		logic       has_zone;
		logic [7:0] event_zone;
		logic [7:0] event_subzone;
	} event_t;

	function automatic logic [7:0] row_byte(input logic [ROW_W-1:0] row, input int idx);
		row_byte = row[idx*8 +: 8];
	endfunction

endpackage

[rtl/erm_table.sv]
// rule table memory, one row per entry, with per-row valid bits for the zero reset
module erm_table #(
	parameter int ROWS = erm_pkg::ROWS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  rd_en,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_addr,
	output logic [erm_pkg::ROW_W-1:0]             rd_data,
	input  logic                                  wr_en,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_addr,
	input  logic [erm_pkg::ROW_W-1:0]             wr_data
);

	logic [erm_pkg::ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]           valid_q;
	logic [erm_pkg::ROW_W-1:0] rd_data_s1;
	logic                      rd_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_ok_s1 <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	// a row never written reads as zeros
	assign rd_data = rd_ok_s1 ? rd_data_s1 : '0;

endmodule

[rtl/erm_row_match.sv]
// decides whether one rule row fires for an event
module erm_row_match (
	input  logic [erm_pkg::ROW_W-1:0] row,
	input  erm_pkg::event_t           ev,
	input  logic [7:0]                node_zone,
	input  logic [7:0]                node_subzone,
	output logic                      fire
);

	logic [7:0] flags;
	logic [8:0] cmask;
	logic [8:0] cfilt;
	logic [7:0] tmask;
	logic [7:0] tfilt;
	logic       ok_en;
	logic       ok_oaddr;
	logic       ok_hard;
	logic       ok_zone;
	logic       ok_class;
	logic       ok_type;

	always_comb begin
		flags = erm_pkg::row_byte(row, erm_pkg::B_FLAGS);
		cmask = {1'b0, erm_pkg::row_byte(row, erm_pkg::B_CMASK)}
			| (flags[erm_pkg::FL_CMASK8] ? erm_pkg::CLASS_BIT8 : 9'd0);
		cfilt = {1'b0, erm_pkg::row_byte(row, erm_pkg::B_CFILT)}
			| (flags[erm_pkg::FL_CFILT8] ? erm_pkg::CLASS_BIT8 : 9'd0);
		tmask = erm_pkg::row_byte(row, erm_pkg::B_TMASK);
		tfilt = erm_pkg::row_byte(row, erm_pkg::B_TFILT);

		ok_en    = flags[erm_pkg::FL_ENABLE]
			&& (erm_pkg::row_byte(row, erm_pkg::B_ACTION) != 8'd0);
		ok_oaddr = !flags[erm_pkg::FL_OADDR]
			|| (erm_pkg::row_byte(row, erm_pkg::B_OADDR) == ev.orig_addr);
		ok_hard  = !flags[erm_pkg::FL_HARD] || ev.hard_coded;
		ok_zone  = (!flags[erm_pkg::FL_ZONE] && !flags[erm_pkg::FL_SUBZONE])
			|| (ev.has_zone
				&& (!flags[erm_pkg::FL_ZONE] || ev.event_zone == node_zone)
				&& (!flags[erm_pkg::FL_SUBZONE] || ev.event_subzone == node_subzone));
		ok_class = (cmask == 9'd0) || (cfilt == (cmask & ev.event_class));
		ok_type  = (tmask == 8'd0) || (tfilt == (tmask & ev.event_type));

		fire = ok_en && ok_oaddr && ok_hard && ok_zone && ok_class && ok_type;
	end

endmodule

[rtl/event_rule_matrix_matcher.sv]
// top level of the event rule matrix matcher: request sequencer and result register
//
// Input channel (in_valid / in_stall) takes one request at a time: a table byte
// write, a table byte read, or an event. Table bytes sit at a linear address,
// row times eight plus byte; an address beyond the table reads 0 and writes nothing.
// Each access gives one reply (kind 0, last set) when the output register is free.
// An event reads the rows from one memory port, one row a cycle while no result is
// held back, and stops after the last row or the sixteenth firing row.
// Each firing row gives a kind 1 result; the last result of the event has last
// set; when no row fires a single kind 2 result is given.
// Results leave through a one-deep output register (out_valid / out_stall).
// While the receiver stalls, the scan pauses at the next firing row and in_stall
// stays high until the request has handed over its last result.
// Requests of type 3 are taken and give no result. Reset clears the whole table to
// zeros (per-row valid bits, no clearing pass), node_zone and node_subzone; in_stall
// is low straight after reset. cfg_we writes node_zone (index 0) or node_subzone
// (index 1); the user must do so only while idle, the block does not enforce it.
module event_rule_matrix_matcher #(
	parameter int ROWS = erm_pkg::ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [7:0] table_addr,
	input  logic [7:0] write_value,
	input  logic [7:0] orig_addr,
	input  logic       hard_coded,
	input  logic [8:0] event_class,
	input  logic [7:0] event_type,
	input  logic       has_zone,
	input  logic [7:0] event_zone,
	input  logic [7:0] event_subzone,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] read_value,
	output logic [3:0] row_index,
	output logic [7:0] action_code,
	output logic [7:0] action_param,
	output logic       last,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_wdata
);

	localparam int RIDX_W      = ROWS > 1 ? $clog2(ROWS) : 1;
	localparam int TABLE_BYTES = ROWS * erm_pkg::ROW_BYTES;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ACC    = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;

	logic [2:0]                 state_q;
	logic [7:0]                 node_zone_q;
	logic [7:0]                 node_subzone_q;
	erm_pkg::event_t            ev_q;
	logic                       is_write_q;
	logic                       in_range_q;
	logic [RIDX_W-1:0]          acc_row_q;
	logic [erm_pkg::BYTE_W-1:0] acc_byte_q;
	logic [7:0]                 wval_q;
	logic [RIDX_W-1:0]          ridx_q;
	logic [erm_pkg::CNT_W-1:0]  cnt_q;
	logic                       pend_q;
	logic [RIDX_W-1:0]          pend_row_q;
	logic [7:0]                 pend_act_q;
	logic [7:0]                 pend_par_q;

	logic                       out_valid_q;
	logic [1:0]                 kind_q;
	logic [7:0]                 read_value_q;
	logic [3:0]                 row_index_q;
	logic [7:0]                 action_code_q;
	logic [7:0]                 action_param_q;
	logic                       last_q;

	logic                       accept;
	logic                       addr_in_range;
	logic                       out_can_load;
	logic                       rd_en;
	logic [RIDX_W-1:0]          rd_addr;
	logic [erm_pkg::ROW_W-1:0]  rd_data;
	logic                       wr_en;
	logic [erm_pkg::ROW_W-1:0]  wr_data;
	logic                       fire;
	logic                       scan_hold;
	logic                       scan_end;
	logic [7:0]                 acc_byte_val;

	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && !in_stall;
	assign addr_in_range = ({1'b0, table_addr} < 9'(TABLE_BYTES));
	assign out_can_load  = !out_valid_q || !out_stall;

	erm_row_match u_match (
		.row          (rd_data),
		.ev           (ev_q),
		.node_zone    (node_zone_q),
		.node_subzone (node_subzone_q),
		.fire         (fire)
	);

	assign scan_hold = fire && pend_q && !out_can_load;
	assign scan_end  = (ridx_q == RIDX_W'(ROWS - 1))
		|| (fire && cnt_q == erm_pkg::CNT_W'(erm_pkg::MAX_OUT - 1));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ridx_q + 1'b1;
		if (accept) begin
			if (req_type == erm_pkg::REQ_EVENT) begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end else begin
				rd_en   = addr_in_range
					&& (req_type == erm_pkg::REQ_WRITE || req_type == erm_pkg::REQ_READ);
				rd_addr = table_addr[3 +: RIDX_W];
			end
		end else if (state_q == ST_SCAN && !scan_hold && !scan_end) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		acc_byte_val = rd_data[{acc_byte_q, 3'b000} +: 8];
		wr_data      = rd_data;
		wr_data[{acc_byte_q, 3'b000} +: 8] = wval_q;
		wr_en        = (state_q == ST_ACC) && out_can_load && is_write_q && in_range_q;
	end

	erm_table #(
		.ROWS (ROWS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (acc_row_q),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_zone_q    <= '0;
			node_subzone_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				erm_pkg::CFG_ZONE:    node_zone_q    <= cfg_wdata;
				erm_pkg::CFG_SUBZONE: node_subzone_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q.orig_addr     <= orig_addr;
			ev_q.hard_coded    <= hard_coded;
			ev_q.event_class   <= event_class;
			ev_q.event_type    <= event_type;
			ev_q.has_zone      <= has_zone;
			ev_q.event_zone    <= event_zone;
			ev_q.event_subzone <= event_subzone;
			is_write_q         <= (req_type == erm_pkg::REQ_WRITE);
			in_range_q         <= addr_in_range;
			acc_row_q          <= table_addr[3 +: RIDX_W];
			acc_byte_q         <= table_addr[erm_pkg::BYTE_W-1:0];
			wval_q             <= write_value;
		end
		if (state_q == ST_SCAN && fire && !scan_hold) begin
			pend_row_q <= ridx_q;
			pend_act_q <= erm_pkg::row_byte(rd_data, erm_pkg::B_ACTION);
			pend_par_q <= erm_pkg::row_byte(rd_data, erm_pkg::B_PARAM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ridx_q         <= '0;
			cnt_q          <= '0;
			pend_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			kind_q         <= erm_pkg::KIND_ACCESS;
			read_value_q   <= '0;
			row_index_q    <= '0;
			action_code_q  <= '0;
			action_param_q <= '0;
			last_q         <= 1'b0;
		end else begin
			if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ridx_q <= '0;
						cnt_q  <= '0;
						pend_q <= 1'b0;
						case (req_type)
							erm_pkg::REQ_WRITE: state_q <= ST_ACC;
							erm_pkg::REQ_READ:  state_q <= ST_ACC;
							erm_pkg::REQ_EVENT: state_q <= ST_SCAN;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACC: begin
					if (out_can_load) begin
						out_valid_q    <= 1'b1;
						kind_q         <= erm_pkg::KIND_ACCESS;
						read_value_q   <= !in_range_q ? 8'd0
							: (is_write_q ? wval_q : acc_byte_val);
						row_index_q    <= '0;
						action_code_q  <= '0;
						action_param_q <= '0;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!scan_hold) begin
						if (fire) begin
							cnt_q  <= cnt_q + 1'b1;
							pend_q <= 1'b1;
							if (pend_q) begin
								out_valid_q    <= 1'b1;
								kind_q         <= erm_pkg::KIND_FIRE;
								read_value_q   <= '0;
								row_index_q    <= 4'(pend_row_q);
								action_code_q  <= pend_act_q;
								action_param_q <= pend_par_q;
								last_q         <= 1'b0;
							end
						end
						if (scan_end)
							state_q <= ST_FINISH;
						else
							ridx_q <= ridx_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_can_load) begin
						out_valid_q    <= 1'b1;
						kind_q         <= pend_q ? erm_pkg::KIND_FIRE : erm_pkg::KIND_NOFIRE;
						read_value_q   <= '0;
						row_index_q    <= pend_q ? 4'(pend_row_q) : 4'd0;
						action_code_q  <= pend_q ? pend_act_q : 8'd0;
						action_param_q <= pend_q ? pend_par_q : 8'd0;
						last_q         <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign read_value   = read_value_q;
	assign row_index    = row_index_q;
	assign action_code  = action_code_q;
	assign action_param = action_param_q;
	assign last         = last_q;

	a_access_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == erm_pkg::KIND_ACCESS) |-> last)
		else $error("access reply without last");

	a_fire_has_action: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == erm_pkg::KIND_FIRE) |-> (action_code != 8'd0))
		else $error("fired result with empty action");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q < erm_pkg::CNT_W'(erm_pkg::MAX_OUT)))
		else $error("scan running past the result limit");

	a_hold_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_hold) |=> ($stable(ridx_q) && state_q == ST_SCAN))
		else $error("scan advanced while a result was blocked");

endmodule

[test/event_rule_matrix_matcher_test.sv]
// self-checking testbench of the event rule matrix matcher: table access, rule checks, random traffic
module event_rule_matrix_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_BYTES = erm_pkg::ROWS_DEF * erm_pkg::ROW_BYTES;
	localparam int QUIET_CYCLES = erm_pkg::ROWS_DEF + 8;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [7:0] F_EN      = 8'(1 << erm_pkg::FL_ENABLE);
	localparam logic [7:0] F_OADDR   = 8'(1 << erm_pkg::FL_OADDR);
	localparam logic [7:0] F_HARD    = 8'(1 << erm_pkg::FL_HARD);
	localparam logic [7:0] F_ZONE    = 8'(1 << erm_pkg::FL_ZONE);
	localparam logic [7:0] F_SUBZONE = 8'(1 << erm_pkg::FL_SUBZONE);
	localparam logic [7:0] F_CMASK8  = 8'(1 << erm_pkg::FL_CMASK8);
	localparam logic [7:0] F_CFILT8  = 8'(1 << erm_pkg::FL_CFILT8);

	typedef struct packed {
		logic [1:0]      req_type;
		logic [7:0]      table_addr;
		logic [7:0]      write_value;
		erm_pkg::event_t ev;
	} request_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] read_value;
		logic [3:0] row_index;
		logic [7:0] action_code;
		logic [7:0] action_param;
		logic       last;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] req_type = erm_pkg::REQ_READ;
	logic [7:0] table_addr = '0;
	logic [7:0] write_value = '0;
	logic [7:0] orig_addr = '0;
	logic       hard_coded = 1'b0;
	logic [8:0] event_class = '0;
	logic [7:0] event_type = '0;
	logic       has_zone = 1'b0;
	logic [7:0] event_zone = '0;
	logic [7:0] event_subzone = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] read_value;
	logic [3:0] row_index;
	logic [7:0] action_code;
	logic [7:0] action_param;
	logic       last;
	logic       cfg_we = 1'b0;
	logic       cfg_idx = erm_pkg::CFG_ZONE;
	logic [7:0] cfg_wdata = '0;

	logic [7:0] rule_mem [TABLE_BYTES];
	logic [7:0] zone_reg;
	logic [7:0] subzone_reg;
	result_t    pending_results [$];
	int         fails = 0;
	int         accepted_items = 0;
	int         idle_pct = 29;
	int         stall_pct = 29;

	event_rule_matrix_matcher i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic bit row_matches(input int r, input erm_pkg::event_t ev);
		int         base;
		logic [7:0] fl;
		logic [8:0] cm;
		logic [8:0] cf;
		logic [7:0] tm;
		logic [7:0] tf;
		base = r * erm_pkg::ROW_BYTES;
		fl = rule_mem[base + erm_pkg::B_FLAGS];
		cm = {fl[erm_pkg::FL_CMASK8], rule_mem[base + erm_pkg::B_CMASK]};
		cf = {fl[erm_pkg::FL_CFILT8], rule_mem[base + erm_pkg::B_CFILT]};
		tm = rule_mem[base + erm_pkg::B_TMASK];
		tf = rule_mem[base + erm_pkg::B_TFILT];
		if (!fl[erm_pkg::FL_ENABLE] || rule_mem[base + erm_pkg::B_ACTION] == '0)
			return 1'b0;
		if (fl[erm_pkg::FL_OADDR] && rule_mem[base + erm_pkg::B_OADDR] != ev.orig_addr)
			return 1'b0;
		if (fl[erm_pkg::FL_HARD] && !ev.hard_coded)
			return 1'b0;
		if ((fl[erm_pkg::FL_ZONE] || fl[erm_pkg::FL_SUBZONE]) && !ev.has_zone)
			return 1'b0;
		if (fl[erm_pkg::FL_ZONE] && ev.event_zone != zone_reg)
			return 1'b0;
		if (fl[erm_pkg::FL_SUBZONE] && ev.event_subzone != subzone_reg)
			return 1'b0;
		if (cm != '0 && cf != (cm & ev.event_class))
			return 1'b0;
		if (tm != '0 && tf != (tm & ev.event_type))
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic void model_request(input request_t rq);
		result_t                      res;
		logic [erm_pkg::ROWS_DEF-1:0] hit;
		int                           n;
		int                           last_row;
		res = '0;
		case (rq.req_type)
			erm_pkg::REQ_WRITE, erm_pkg::REQ_READ: begin
				res.kind = erm_pkg::KIND_ACCESS;
				res.last = 1'b1;
				if (rq.table_addr < TABLE_BYTES) begin
					if (rq.req_type == erm_pkg::REQ_WRITE)
						rule_mem[rq.table_addr] = rq.write_value;
					res.read_value = rule_mem[rq.table_addr];
				end
				pending_results.push_back(res);
			end
			erm_pkg::REQ_EVENT: begin
				hit = '0;
				n = 0;
				last_row = -1;
				for (int r = 0; r < erm_pkg::ROWS_DEF; r++)
					if (n < erm_pkg::MAX_OUT && row_matches(r, rq.ev)) begin
						hit[r] = 1'b1;
						n++;
						last_row = r;
					end
				if (n == 0) begin
					res.kind = erm_pkg::KIND_NOFIRE;
					res.last = 1'b1;
					pending_results.push_back(res);
				end
				for (int r = 0; r < erm_pkg::ROWS_DEF; r++)
					if (hit[r]) begin
						res = '0;
						res.kind = erm_pkg::KIND_FIRE;
						res.row_index = 4'(r);
						res.action_code = rule_mem[r * erm_pkg::ROW_BYTES + erm_pkg::B_ACTION];
						res.action_param = rule_mem[r * erm_pkg::ROW_BYTES + erm_pkg::B_PARAM];
						res.last = (r == last_row);
						pending_results.push_back(res);
					end
			end
			default: ;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected: kind %0d row %0d", kind, row_index);
				fails++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("read_value", want.read_value, read_value);
				check_field("row_index", want.row_index, row_index);
				check_field("action_code", want.action_code, action_code);
				check_field("action_param", want.action_param, action_param);
				check_field("last", want.last, last);
			end
		end
	end

	task automatic issue_request(input request_t rq);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq.req_type;
		table_addr <= rq.table_addr;
		write_value <= rq.write_value;
		orig_addr <= rq.ev.orig_addr;
		hard_coded <= rq.ev.hard_coded;
		event_class <= rq.ev.event_class;
		event_type <= rq.ev.event_type;
		has_zone <= rq.ev.has_zone;
		event_zone <= rq.ev.event_zone;
		event_subzone <= rq.ev.event_subzone;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		model_request(rq);
		if (rq.req_type != REQ_UNUSED)
			accepted_items++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_zones(input logic [7:0] z, input logic [7:0] s);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= erm_pkg::CFG_ZONE;
		cfg_wdata <= z;
		@(posedge clk);
		cfg_idx <= erm_pkg::CFG_SUBZONE;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		zone_reg = z;
		subzone_reg = s;
	endtask

	function automatic erm_pkg::event_t random_event();
		erm_pkg::event_t ev;
		ev.orig_addr = 8'($urandom);
		ev.hard_coded = 1'($urandom);
		ev.event_class = 9'($urandom);
		ev.event_type = 8'($urandom);
		ev.has_zone = 1'($urandom);
		ev.event_zone = 8'($urandom);
		ev.event_subzone = 8'($urandom);
		return ev;
	endfunction

	// event built to pass most of the checks of one row
	function automatic erm_pkg::event_t event_for_row(input int r);
		erm_pkg::event_t ev;
		int              base;
		logic [7:0]      fl;
		logic [8:0]      cm;
		logic [8:0]      cf;
		logic [7:0]      tm;
		logic [7:0]      tf;
		base = r * erm_pkg::ROW_BYTES;
		fl = rule_mem[base + erm_pkg::B_FLAGS];
		cm = {fl[erm_pkg::FL_CMASK8], rule_mem[base + erm_pkg::B_CMASK]};
		cf = {fl[erm_pkg::FL_CFILT8], rule_mem[base + erm_pkg::B_CFILT]};
		tm = rule_mem[base + erm_pkg::B_TMASK];
		tf = rule_mem[base + erm_pkg::B_TFILT];
		ev = random_event();
		if ($urandom_range(9) != 0)
			ev.orig_addr = rule_mem[base + erm_pkg::B_OADDR];
		if ($urandom_range(9) != 0)
			ev.hard_coded = 1'b1;
		if ($urandom_range(9) != 0)
			ev.has_zone = 1'b1;
		if ($urandom_range(7) != 0)
			ev.event_zone = zone_reg;
		if ($urandom_range(7) != 0)
			ev.event_subzone = subzone_reg;
		if ($urandom_range(9) != 0)
			ev.event_class = (cf & cm) | (ev.event_class & ~cm);
		if ($urandom_range(9) != 0)
			ev.event_type = (tf & tm) | (ev.event_type & ~tm);
		return ev;
	endfunction

	function automatic request_t access_req(input logic [1:0] op, input int addr, input int val);
		request_t rq;
		rq.req_type = op;
		rq.table_addr = 8'(addr);
		rq.write_value = 8'(val);
		rq.ev = random_event();
		return rq;
	endfunction

	task automatic table_write(input int addr, input int val);
		issue_request(access_req(erm_pkg::REQ_WRITE, addr, val));
	endtask

	task automatic table_read(input int addr);
		issue_request(access_req(erm_pkg::REQ_READ, addr, $urandom_range(255)));
	endtask

	task automatic send_event(input erm_pkg::event_t ev);
		request_t rq;
		rq = access_req(erm_pkg::REQ_EVENT, $urandom_range(255), $urandom_range(255));
		rq.ev = ev;
		issue_request(rq);
	endtask

	task automatic test_table_access();
		request_t rq;
		table_write(0, 8'hFF);
		table_read(0);
		table_write(TABLE_BYTES - 1, 8'h5A);
		table_read(TABLE_BYTES - 1);
		table_write(TABLE_BYTES, 8'hA5);
		table_read(TABLE_BYTES);
		table_read(8'hFF);
		// unused request type, all bits set
		rq = '1;
		rq.req_type = REQ_UNUSED;
		issue_request(rq);
		table_write(0, 8'h00);
	endtask

	task automatic test_rule_checks();
		erm_pkg::event_t ev;
		int              base;
		set_zones(8'h12, 8'h34);
		base = 3 * erm_pkg::ROW_BYTES;
		table_write(base + erm_pkg::B_OADDR, 8'h55);
		table_write(base + erm_pkg::B_FLAGS,
			F_EN | F_OADDR | F_HARD | F_ZONE | F_SUBZONE | F_CMASK8 | F_CFILT8);
		table_write(base + erm_pkg::B_CMASK, 8'h0F);
		table_write(base + erm_pkg::B_CFILT, 8'h05);
		table_write(base + erm_pkg::B_TMASK, 8'hF0);
		table_write(base + erm_pkg::B_TFILT, 8'hA0);
		table_write(base + erm_pkg::B_ACTION, 8'h07);
		table_write(base + erm_pkg::B_PARAM, 8'hFF);
		ev = '{orig_addr: 8'h55, hard_coded: 1'b1, event_class: 9'h1F5, event_type: 8'hAB,
			has_zone: 1'b1, event_zone: 8'h12, event_subzone: 8'h34};
		send_event(ev);
		// zone checks asked for but event carries no zone
		ev.has_zone = 1'b0;
		send_event(ev);
		ev.has_zone = 1'b1;
		ev.event_class = 9'h0F5;
		send_event(ev);
		ev.event_class = 9'h1F5;
		ev.orig_addr = 8'h56;
		send_event(ev);
		// filter bit outside the class mask
		ev.orig_addr = 8'h55;
		table_write(base + erm_pkg::B_CFILT, 8'h15);
		send_event(ev);
		// zero masks pass whatever the filters hold
		table_write(base + erm_pkg::B_FLAGS, F_EN | F_OADDR | F_HARD | F_ZONE | F_SUBZONE);
		table_write(base + erm_pkg::B_CMASK, 8'h00);
		table_write(base + erm_pkg::B_TMASK, 8'h00);
		ev.event_class = 9'h000;
		ev.event_type = 8'h00;
		send_event(ev);
	endtask

	// every row fires at once, with no idling on either side
	task automatic test_all_rows_fire();
		idle_pct = 0;
		stall_pct = 0;
		for (int r = 0; r < erm_pkg::ROWS_DEF; r++) begin
			table_write(r * erm_pkg::ROW_BYTES + erm_pkg::B_FLAGS, F_EN);
			table_write(r * erm_pkg::ROW_BYTES + erm_pkg::B_CMASK, 8'h00);
			table_write(r * erm_pkg::ROW_BYTES + erm_pkg::B_TMASK, 8'h00);
			table_write(r * erm_pkg::ROW_BYTES + erm_pkg::B_ACTION, r + 1);
		end
		send_event(random_event());
		send_event(random_event());
		table_read(8'd0);
		table_write(erm_pkg::B_ACTION, 8'hFF);
		send_event(random_event());
		idle_pct = 29;
		stall_pct = 29;
	endtask

	task automatic test_random_traffic(input logic [7:0] z, input logic [7:0] s,
		input int target_items);
		int         pick;
		int         r;
		int         b;
		logic [7:0] v;
		set_zones(z, s);
		while (accepted_items < target_items) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				r = $urandom_range(erm_pkg::ROWS_DEF - 1);
				b = $urandom_range(erm_pkg::ROW_BYTES - 1);
				v = 8'($urandom);
				case (b)
					erm_pkg::B_FLAGS: v[erm_pkg::FL_ENABLE] = ($urandom_range(9) != 0);
					erm_pkg::B_CMASK, erm_pkg::B_TMASK: if ($urandom_range(3) == 0) v = '0;
					erm_pkg::B_CFILT, erm_pkg::B_TFILT:
						if ($urandom_range(4) != 0) v &= rule_mem[r * erm_pkg::ROW_BYTES + b - 1];
					erm_pkg::B_ACTION: if ($urandom_range(9) == 0) v = '0;
					default: ;
				endcase
				table_write(r * erm_pkg::ROW_BYTES + b, v);
			end else if (pick < 50) begin
				if ($urandom_range(3) == 0)
					table_read($urandom_range(255));
				else
					table_read($urandom_range(TABLE_BYTES - 1));
			end else if (pick < 85) begin
				send_event(event_for_row($urandom_range(erm_pkg::ROWS_DEF - 1)));
			end else if (pick < 95) begin
				send_event(random_event());
			end else if (pick < 98) begin
				table_write($urandom_range(255, TABLE_BYTES), $urandom_range(255));
			end else begin
				issue_request(access_req(REQ_UNUSED, $urandom_range(255), $urandom_range(255)));
			end
		end
	endtask

	initial begin
		foreach (rule_mem[i])
			rule_mem[i] = '0;
		zone_reg = '0;
		subzone_reg = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_access();
		test_rule_checks();
		test_all_rows_fire();
		test_random_traffic(8'hFF, 8'h00, 140);
		test_random_traffic(8'h00, 8'hFF, 185);
		test_random_traffic(8'($urandom), 8'($urandom), 230);
		test_random_traffic(8'hFF, 8'hFF, 275);
		wait_idle();
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
